// File: sv/qte_pkg.sv
package qte_pkg;

    localparam int TURN_W = 32;
    localparam int Q_W    = 36;
    localparam int LANE_W = 40;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 34;

    typedef logic [TURN_W-1:0]        turn_t;
    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [LANE_W-1:0] lane_t;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    localparam q_t    ONE_Q30      = 36'sh0_4000_0000;
    localparam turn_t HALF_TURN    = 32'h8000_0000;
    localparam turn_t QUARTER_TURN = 32'h4000_0000;

    // atan(2^-i) as a 32-bit binary angle
    localparam turn_t ARC_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic [1:0] pole;
        q_t         pitch_s;
        q_t         yaw_y;
        q_t         yaw_x;
        q_t         roll_y;
        q_t         roll_x;
    } side_t;

endpackage

// File: sv/qte_if.sv
interface qte_quat_if #(parameter int COMPONENT_BITS = 16);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
    logic signed [COMPONENT_BITS-1:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

interface qte_euler_if #(parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic [1:0]                   pole_branch;

    modport source (output valid, output pitch_angle, output yaw_angle,
                    output roll_angle, output pole_branch, input ready);
    modport sink   (input valid, input pitch_angle, input yaw_angle,
                    input roll_angle, input pole_branch, output ready);
endinterface

// File: sv/qte_front.sv
module qte_front #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [COMPONENT_BITS-1:0] x,
    input  logic signed [COMPONENT_BITS-1:0] y,
    input  logic signed [COMPONENT_BITS-1:0] z,
    input  logic signed [COMPONENT_BITS-1:0] w,
    output logic                             out_valid,
    output qte_pkg::side_t                   side,
    output logic [qte_pkg::SQ_W-1:0]         s_sq
);
    localparam int CB   = COMPONENT_BITS;
    localparam int FR   = 2 * (CB - 1);
    localparam int SHR  = (FR >= 30) ? FR - 30 : 0;
    localparam int SHL  = (FR >= 30) ? 0 : 30 - FR;
    localparam int FC   = CB - 1;
    localparam int SHRC = (FC >= 30) ? FC - 30 : 0;
    localparam int SHLC = (FC >= 30) ? 0 : 30 - FC;

    function automatic qte_pkg::q_t mul_q30(input logic signed [CB-1:0] a,
                                            input logic signed [CB-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        if (FR >= 30)
            return qte_pkg::q_t'(p >>> SHR);
        else
            return qte_pkg::q_t'(p <<< SHL);
    endfunction

    function automatic qte_pkg::q_t comp_q30(input logic signed [CB-1:0] a);
        logic signed [63:0] e;
        e = 64'(a);
        if (FC >= 30)
            return qte_pkg::q_t'(e >>> SHRC);
        else
            return qte_pkg::q_t'(e <<< SHLC);
    endfunction

    // stage 1: products
    logic        v1_reg;
    qte_pkg::q_t sqx_reg, sqy_reg, sqz_reg, sqw_reg;
    qte_pkg::q_t xw_reg, yz_reg, wy_reg, zx_reg, wz_reg, xy_reg, xq1_reg, yq1_reg;
    // stage 2: sums
    logic        v2_reg;
    qte_pkg::q_t unit_reg, test_reg, yawy2_reg, yawx2_reg, rolly2_reg, rollx2_reg;
    qte_pkg::q_t xq2_reg, yq2_reg;
    // stage 3: branch decision
    logic        v3_reg;
    logic [1:0]  pole3_reg;
    qte_pkg::q_t s3_reg, yawy3_reg, yawx3_reg, rolly3_reg, rollx3_reg, xq3_reg, yq3_reg;
    // stage 4: square of the asin argument
    logic        v4_reg;
    qte_pkg::side_t side4_reg;
    logic [qte_pkg::SQ_W-1:0] sq4_reg;

    logic signed [47:0] lhs, rhs;
    qte_pkg::q_t        s2, s_clamp;
    logic [1:0]         pole_next;
    logic signed [31:0] s32;
    logic signed [63:0] s_prod;
    qte_pkg::side_t     side_next;

    always_comb
    begin
        lhs = 48'(test_reg) * 48'sd2000;
        rhs = 48'(unit_reg) * 48'sd999;
        if (lhs > rhs)
            pole_next = qte_pkg::POLE_NORTH;
        else if (lhs < -rhs)
            pole_next = qte_pkg::POLE_SOUTH;
        else
            pole_next = qte_pkg::POLE_NONE;
        s2 = test_reg <<< 1;
        if (s2 > qte_pkg::ONE_Q30)
            s_clamp = qte_pkg::ONE_Q30;
        else if (s2 < -qte_pkg::ONE_Q30)
            s_clamp = -qte_pkg::ONE_Q30;
        else
            s_clamp = s2;
    end

    always_comb
    begin
        s32    = 32'(s3_reg);
        s_prod = 64'(s32) * 64'(s32);
        side_next.pole    = pole3_reg;
        side_next.pitch_s = s3_reg;
        side_next.roll_y  = rolly3_reg;
        side_next.roll_x  = rollx3_reg;
        // at a pole the yaw lane takes atan2(y, x) of the raw components
        if (pole3_reg != qte_pkg::POLE_NONE)
        begin
            side_next.yaw_y = yq3_reg;
            side_next.yaw_x = xq3_reg;
        end
        else
        begin
            side_next.yaw_y = yawy3_reg;
            side_next.yaw_x = yawx3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= mul_q30(x, x);
            sqy_reg <= mul_q30(y, y);
            sqz_reg <= mul_q30(z, z);
            sqw_reg <= mul_q30(w, w);
            xw_reg  <= mul_q30(x, w);
            yz_reg  <= mul_q30(y, z);
            wy_reg  <= mul_q30(w, y);
            zx_reg  <= mul_q30(z, x);
            wz_reg  <= mul_q30(w, z);
            xy_reg  <= mul_q30(x, y);
            xq1_reg <= comp_q30(x);
            yq1_reg <= comp_q30(y);

            unit_reg   <= sqx_reg + sqy_reg + sqz_reg + sqw_reg;
            test_reg   <= xw_reg - yz_reg;
            yawy2_reg  <= (wy_reg + zx_reg) <<< 1;
            yawx2_reg  <= qte_pkg::ONE_Q30 - ((sqx_reg + sqy_reg) <<< 1);
            rolly2_reg <= (wz_reg + xy_reg) <<< 1;
            rollx2_reg <= qte_pkg::ONE_Q30 - ((sqz_reg + sqx_reg) <<< 1);
            xq2_reg    <= xq1_reg;
            yq2_reg    <= yq1_reg;

            pole3_reg  <= pole_next;
            s3_reg     <= s_clamp;
            yawy3_reg  <= yawy2_reg;
            yawx3_reg  <= yawx2_reg;
            rolly3_reg <= rolly2_reg;
            rollx3_reg <= rollx2_reg;
            xq3_reg    <= xq2_reg;
            yq3_reg    <= yq2_reg;

            side4_reg <= side_next;
            sq4_reg   <= s_prod[qte_pkg::SQ_W-1:0];
        end
    end

    assign out_valid = v4_reg;
    assign side      = side4_reg;
    assign s_sq      = sq4_reg;

endmodule

// File: sv/qte_sqrt.sv
module qte_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  qte_pkg::side_t             in_side,
    input  logic [qte_pkg::SQ_W-1:0]   s_sq,
    output logic                       out_valid,
    output qte_pkg::side_t             out_side,
    output logic [qte_pkg::ROOT_W-1:0] root
);
    localparam int N = qte_pkg::ROOT_W;
    localparam int W = qte_pkg::SQ_W;
    localparam int R = qte_pkg::REM_W;

    logic           v_reg    [0:N];
    qte_pkg::side_t side_reg [0:N];
    logic [W-1:0]   n_reg    [0:N];
    logic [R-1:0]   rem_reg  [0:N];
    logic [N-1:0]   root_reg [0:N];

    // load: radicand is one minus the squared argument
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            n_reg[0]    <= (W'(1) << 60) - s_sq;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one result bit per stage, two radicand bits consumed
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [R-1:0] rem_t;
        logic [R-1:0] trial;
        logic [R-1:0] rem_n;
        logic [N-1:0] root_n;

        always_comb
        begin
            rem_t = {rem_reg[k][R-3:0], n_reg[k][W-1:W-2]};
            trial = R'({root_reg[k], 2'b01});
            if (rem_t >= trial)
            begin
                rem_n  = rem_t - trial;
                root_n = {root_reg[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_n  = rem_t;
                root_n = {root_reg[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                n_reg[k+1]    <= n_reg[k] << 2;
                rem_reg[k+1]  <= rem_n;
                root_reg[k+1] <= root_n;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_side  = side_reg[N];
    assign root      = root_reg[N];

endmodule

// File: sv/qte_cordic.sv
module qte_cordic #(
    parameter int ARC_STAGES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  qte_pkg::side_t             in_side,
    input  logic [qte_pkg::ROOT_W-1:0] root,
    output logic                       out_valid,
    output logic [1:0]                 out_pole,
    output qte_pkg::turn_t             z_pitch,
    output qte_pkg::turn_t             z_yaw,
    output qte_pkg::turn_t             z_roll
);
    localparam int S = ARC_STAGES;

    logic           v_reg    [0:S];
    logic [1:0]     pole_reg [0:S];

    qte_pkg::lane_t in_y [3];
    qte_pkg::lane_t in_x [3];

    always_comb
    begin
        in_y[0] = qte_pkg::LANE_W'(in_side.pitch_s);
        in_x[0] = qte_pkg::LANE_W'($signed({1'b0, root}));
        in_y[1] = qte_pkg::LANE_W'(in_side.yaw_y);
        in_x[1] = qte_pkg::LANE_W'(in_side.yaw_x);
        in_y[2] = qte_pkg::LANE_W'(in_side.roll_y);
        in_x[2] = qte_pkg::LANE_W'(in_side.roll_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pole_reg[0] <= in_side.pole;
    end

    for (genvar k = 0; k < S; k++)
    begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pole_reg[k+1] <= pole_reg[k];
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        qte_pkg::lane_t x_reg    [0:S];
        qte_pkg::lane_t y_reg    [0:S];
        qte_pkg::turn_t z_reg    [0:S];
        logic           hold_reg [0:S];

        // pre-rotation: fold the left half plane, settle the y == 0 case
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (in_y[l] == '0)
                begin
                    x_reg[0]    <= in_x[l];
                    y_reg[0]    <= in_y[l];
                    z_reg[0]    <= (in_x[l] < 0) ? qte_pkg::HALF_TURN : '0;
                    hold_reg[0] <= 1'b1;
                end
                else if (in_x[l] < 0)
                begin
                    x_reg[0]    <= -in_x[l];
                    y_reg[0]    <= -in_y[l];
                    z_reg[0]    <= qte_pkg::HALF_TURN;
                    hold_reg[0] <= 1'b0;
                end
                else
                begin
                    x_reg[0]    <= in_x[l];
                    y_reg[0]    <= in_y[l];
                    z_reg[0]    <= '0;
                    hold_reg[0] <= 1'b0;
                end
            end
        end

        for (genvar k = 0; k < S; k++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hold_reg[k+1] <= hold_reg[k];
                    if (hold_reg[k])
                    begin
                        x_reg[k+1] <= x_reg[k];
                        y_reg[k+1] <= y_reg[k];
                        z_reg[k+1] <= z_reg[k];
                    end
                    else if (y_reg[k] >= 0)
                    begin
                        x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] + qte_pkg::ARC_TABLE[k];
                    end
                    else
                    begin
                        x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] - qte_pkg::ARC_TABLE[k];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[S];
    assign out_pole  = pole_reg[S];
    assign z_pitch   = g_lane[0].z_reg[S];
    assign z_yaw     = g_lane[1].z_reg[S];
    assign z_roll    = g_lane[2].z_reg[S];

endmodule

// File: sv/quaternion_to_euler.sv
// Quaternion to Euler angle converter. Takes one quaternion per cycle (x, y, z, w in
// signed Q1.(COMPONENT_BITS-1)) and returns pitch, yaw and roll as ANGLE_BITS-bit binary
// angles (full range = -pi..pi) plus a pole code: 0 regular, 1 north, 2 south singularity.
// Fully pipelined: throughput one transaction per cycle while not stalled. The path runs
// through four front stages (products, sums, pole test, squaring), a load stage and a
// one-bit-per-stage 31-stage square root for the asin term, and the CORDIC arc-tangent
// pipeline of ARC_STAGES stages plus its pre-rotation, then the output register. Back
// pressure stalls the whole pipeline in place; an empty output register never stalls it.
module quaternion_to_euler #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_BITS     = 16,
    parameter int ARC_STAGES     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    qte_quat_if.sink    quat_in,
    qte_euler_if.source euler_out
);
    localparam int             SH  = qte_pkg::TURN_W - ANGLE_BITS;
    localparam int             RSH = (SH > 0) ? SH - 1 : 0;
    localparam qte_pkg::turn_t RND = (SH > 0) ? (qte_pkg::turn_t'(1) << RSH) : '0;

    logic en;
    logic out_valid_reg;

    logic                       f_valid;
    qte_pkg::side_t             f_side;
    logic [qte_pkg::SQ_W-1:0]   f_sq;
    logic                       r_valid;
    qte_pkg::side_t             r_side;
    logic [qte_pkg::ROOT_W-1:0] r_root;
    logic                       c_valid;
    logic [1:0]                 c_pole;
    qte_pkg::turn_t             c_pitch, c_yaw, c_roll;

    qte_pkg::turn_t pitch_t, yaw_t, roll_t;
    qte_pkg::turn_t pitch_r, yaw_r, roll_r;

    logic signed [ANGLE_BITS-1:0] pitch_reg, yaw_reg, roll_reg;
    logic [1:0]                   pole_reg;

    assign en            = !out_valid_reg || euler_out.ready;
    assign quat_in.ready = en;

    qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quat_in.valid),
        .x         (quat_in.quat_x),
        .y         (quat_in.quat_y),
        .z         (quat_in.quat_z),
        .w         (quat_in.quat_w),
        .out_valid (f_valid),
        .side      (f_side),
        .s_sq      (f_sq)
    );

    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .s_sq      (f_sq),
        .out_valid (r_valid),
        .out_side  (r_side),
        .root      (r_root)
    );

    qte_cordic #(.ARC_STAGES(ARC_STAGES)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .root      (r_root),
        .out_valid (c_valid),
        .out_pole  (c_pole),
        .z_pitch   (c_pitch),
        .z_yaw     (c_yaw),
        .z_roll    (c_roll)
    );

    always_comb
    begin
        case (c_pole)
            qte_pkg::POLE_NORTH:
            begin
                yaw_t   = c_yaw << 1;
                pitch_t = qte_pkg::QUARTER_TURN;
                roll_t  = '0;
            end
            qte_pkg::POLE_SOUTH:
            begin
                yaw_t   = '0 - (c_yaw << 1);
                pitch_t = '0 - qte_pkg::QUARTER_TURN;
                roll_t  = '0;
            end
            default:
            begin
                yaw_t   = c_yaw;
                pitch_t = '0 - c_pitch;
                roll_t  = '0 - c_roll;
            end
        endcase
        // round half up; a carry into +pi wraps to -pi
        pitch_r = (pitch_t + RND) >> SH;
        yaw_r   = (yaw_t + RND) >> SH;
        roll_r  = (roll_t + RND) >> SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_r[ANGLE_BITS-1:0];
            yaw_reg   <= yaw_r[ANGLE_BITS-1:0];
            roll_reg  <= roll_r[ANGLE_BITS-1:0];
            pole_reg  <= c_pole;
        end
    end

    assign euler_out.valid       = out_valid_reg;
    assign euler_out.pitch_angle = pitch_reg;
    assign euler_out.yaw_angle   = yaw_reg;
    assign euler_out.roll_angle  = roll_reg;
    assign euler_out.pole_branch = pole_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY    = 38 + 16;
    localparam int WATCH_MAX  = 4000;
    localparam logic signed [15:0] MAX_POS = 16'sh7fff;
    localparam logic signed [15:0] MAX_NEG = -16'sh8000;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic [1:0]         pole;
    } euler_t;

    logic clk;
    logic rst_n;

    qte_quat_if  #(.COMPONENT_BITS(16)) quat_in ();
    qte_euler_if #(.ANGLE_BITS(16))     euler_out ();

    quaternion_to_euler #(
        .COMPONENT_BITS(16),
        .ANGLE_BITS    (16),
        .ARC_STAGES    (16)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .quat_in  (quat_in),
        .euler_out(euler_out)
    );

    euler_t angle_queue[$];
    int     error_count;
    int     result_count;
    int     north_count;
    int     south_count;
    int     idle_cycles;
    int     hold_off;
    bit     random_gaps;
    bit     random_stalls;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // arithmetic shift right of a 64-bit value
    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        return (a * b);
    endfunction

    function automatic logic [31:0] cordic_angle(longint y, longint x);
        logic [31:0] acc;
        longint dx;
        longint dy;
        acc = '0;
        if (y == 0)
            return (x < 0) ? qte_pkg::HALF_TURN : 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = qte_pkg::HALF_TURN;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                acc = acc + qte_pkg::ARC_TABLE[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                acc = acc - qte_pkg::ARC_TABLE[i];
            end
        end
        return acc;
    endfunction

    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitpos;
        res = '0;
        bitpos = 64'd1 << 62;
        while (bitpos > n)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (n >= res + bitpos)
            begin
                n = n - (res + bitpos);
                res = (res >> 1) + bitpos;
            end
            else
                res = res >> 1;
            bitpos = bitpos >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] round_angle(logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h8000;
        return r[31:16];
    endfunction

    function automatic euler_t predict_euler(logic signed [15:0] qx, logic signed [15:0] qy,
                                             logic signed [15:0] qz, logic signed [15:0] qw);
        euler_t e;
        longint x, y, z, w;
        longint sqx, sqy, sqz, sqw, unit_sum, test, s, c;
        logic [31:0] pitch, yaw, roll;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        sqx = fix_mul(x, x);
        sqy = fix_mul(y, y);
        sqz = fix_mul(z, z);
        sqw = fix_mul(w, w);
        unit_sum = sqx + sqy + sqz + sqw;
        test = fix_mul(x, w) - fix_mul(y, z);
        if (2000 * test > 999 * unit_sum)
        begin
            yaw   = 32'd2 * cordic_angle(y <<< 15, x <<< 15);
            pitch = qte_pkg::QUARTER_TURN;
            roll  = '0;
            e.pole = qte_pkg::POLE_NORTH;
        end
        else if (2000 * test < -999 * unit_sum)
        begin
            yaw   = 32'd0 - 32'd2 * cordic_angle(y <<< 15, x <<< 15);
            pitch = 32'd0 - qte_pkg::QUARTER_TURN;
            roll  = '0;
            e.pole = qte_pkg::POLE_SOUTH;
        end
        else
        begin
            s = 2 * test;
            if (s > 64'sd1073741824)
                s = 64'sd1073741824;
            if (s < -64'sd1073741824)
                s = -64'sd1073741824;
            c = int_sqrt((64'd1 << 60) - 64'(s * s));
            yaw   = cordic_angle(2 * (fix_mul(w, y) + fix_mul(z, x)),
                                 64'sd1073741824 - 2 * (sqx + sqy));
            pitch = 32'd0 - cordic_angle(s, c);
            roll  = 32'd0 - cordic_angle(2 * (fix_mul(w, z) + fix_mul(x, y)),
                                         64'sd1073741824 - 2 * (sqz + sqx));
            e.pole = qte_pkg::POLE_NONE;
        end
        e.pitch = round_angle(pitch);
        e.yaw   = round_angle(yaw);
        e.roll  = round_angle(roll);
        return e;
    endfunction

    task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw);
        int gap;
        gap = random_gaps && ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            quat_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        quat_in.valid  <= 1'b1;
        quat_in.quat_x <= qx;
        quat_in.quat_y <= qy;
        quat_in.quat_z <= qz;
        quat_in.quat_w <= qw;
        @(posedge clk);
        while (!quat_in.ready)
            @(posedge clk);
        angle_queue.push_back(predict_euler(qx, qy, qz, qw));
        @(negedge clk);
    endtask

    task automatic drop_valid();
        quat_in.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        drop_valid();
        while (angle_queue.size() != 0 && guard < WATCH_MAX * 4)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(MAX_POS, 0, 0, 0);
        send_quat(0, MAX_POS, 0, 0);
        send_quat(0, 0, MAX_POS, 0);
        send_quat(0, 0, 0, MAX_POS);
        send_quat(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        send_quat(MAX_POS, MAX_POS, MAX_POS, MAX_POS);
        // north and south singularities: x*w or -y*z dominant; one case where they cancel
        send_quat(16'sd23170, 0, 0, 16'sd23170);
        send_quat(16'sd23170, 16'sd100, 16'sd0, 16'sd23170);
        send_quat(-16'sd23170, 16'sd5, 0, 16'sd23170);
        send_quat(16'sd23170, -16'sd300, 0, -16'sd23170);
        send_quat(-16'sd16000, 16'sd16000, -16'sd16000, 16'sd16000);
        send_quat(0, MAX_NEG, MAX_POS, 0);
        // unnormalized and degenerate input, including full-scale poles
        send_quat(MAX_POS, 0, 0, MAX_POS);
        send_quat(MAX_NEG, 0, 0, MAX_POS);
        send_quat(MAX_NEG, 16'sd1, 0, 0);
        send_quat(MAX_NEG, 0, 0, 0);
        send_quat(0, 0, MAX_NEG, MAX_NEG);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sd20000, 16'sd10000, -16'sd15000, 16'sd12000);
        wait_drained();
    endtask

    task automatic test_poles(int count);
        logic signed [15:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = 16'($urandom_range(8000, 23170));
            send_quat($urandom_range(0, 1) ? a : -a, 16'($urandom_range(0, 400)) - 16'sd200,
                      16'($urandom_range(0, 400)) - 16'sd200,
                      $urandom_range(0, 1) ? a : -a);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(150);
        wait_drained();
    endtask

    // receiver stall pattern and long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler_out.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            euler_out.ready <= 1'b0;
        end
        else if (random_stalls)
            euler_out.ready <= ($urandom_range(0, 3) != 0);
        else
            euler_out.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && euler_out.valid && euler_out.ready)
        begin
            if (angle_queue.size() == 0)
            begin
                $display("%0t: unexpected transaction pitch %0d yaw %0d roll %0d pole %0d",
                         $time, euler_out.pitch_angle, euler_out.yaw_angle,
                         euler_out.roll_angle, euler_out.pole_branch);
                error_count++;
            end
            else
            begin
                want = angle_queue.pop_front();
                result_count++;
                if (want.pole == qte_pkg::POLE_NORTH)
                    north_count++;
                if (want.pole == qte_pkg::POLE_SOUTH)
                    south_count++;
                if (euler_out.pitch_angle !== want.pitch)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                             euler_out.pitch_angle);
                    error_count++;
                end
                if (euler_out.yaw_angle !== want.yaw)
                begin
                    $display("%0t: yaw expected %0d actual %0d", $time, want.yaw,
                             euler_out.yaw_angle);
                    error_count++;
                end
                if (euler_out.roll_angle !== want.roll)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                             euler_out.roll_angle);
                    error_count++;
                end
                if (euler_out.pole_branch !== want.pole)
                begin
                    $display("%0t: pole expected %0d actual %0d", $time, want.pole,
                             euler_out.pole_branch);
                    error_count++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((quat_in.valid && quat_in.ready) || (euler_out.valid && euler_out.ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_MAX)
        begin
            $display("watchdog expired with %0d results outstanding", angle_queue.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        result_count  = 0;
        north_count   = 0;
        south_count   = 0;
        idle_cycles   = 0;
        hold_off      = 0;
        random_gaps   = 1'b0;
        random_stalls = 1'b0;
        rst_n          = 1'b0;
        quat_in.valid  = 1'b0;
        quat_in.quat_x = '0;
        quat_in.quat_y = '0;
        quat_in.quat_z = '0;
        quat_in.quat_w = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        random_gaps   = 1'b1;
        random_stalls = 1'b1;
        test_poles(200);
        test_random(600);
        wait_drained();
        test_backpressure();
        random_gaps   = 1'b0;
        random_stalls = 1'b0;
        test_random(200);
        random_gaps   = 1'b1;
        random_stalls = 1'b1;
        test_poles(100);
        test_random(330);
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);

        $display("covered %0d quaternions: %0d north and %0d south singularities,",
                 result_count, north_count, south_count);
        $display("extremes, saturated asin, bursts, stalls and a long output hold-off");
        if (error_count == 0 && angle_queue.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
